// ===== hdl/pdcc_pkg.sv =====
// shared types, constants and the controller table for the pot deadband block
// no dependencies
`default_nettype none

package pdcc_pkg;

    localparam int POT_COUNT_DEFAULT = 16;
    localparam int IDX_W             = 7;
    localparam int TABLE_SIZE        = 16;

    localparam int RAW_W  = 10;
    localparam int VAL_W  = 7;
    localparam int SENT_W = 8;
    localparam int CH_W   = 5;
    localparam int SRC_W  = 5;

    localparam logic [2:0] REG_DECK_A_CHANNEL  = 3'd0;
    localparam logic [2:0] REG_DECK_B_CHANNEL  = 3'd1;
    localparam logic [2:0] REG_CUE_MIX_MODE    = 3'd2;
    localparam logic [2:0] REG_RAW_THRESHOLD   = 3'd3;
    localparam logic [2:0] REG_VALUE_THRESHOLD = 3'd4;

    localparam logic [CH_W-1:0]  DECK_A_RESET          = 5'd2;
    localparam logic [CH_W-1:0]  DECK_B_RESET          = 5'd3;
    localparam logic [RAW_W-1:0] RAW_THRESHOLD_RESET   = 10'd15;
    localparam logic [VAL_W-1:0] VALUE_THRESHOLD_RESET = 7'd3;

    localparam logic [CH_W-1:0]   GLOBAL_CHANNEL = 5'd1;
    localparam logic [CH_W-1:0]   XF_CHANNEL     = 5'd1;
    localparam logic [VAL_W-1:0]  XF_CC          = 7'd8;
    localparam logic [VAL_W-1:0]  CUE_ALT_CC     = 7'd40;
    localparam logic [SRC_W-1:0]  CUE_POT        = 5'd1;
    localparam logic [SRC_W-1:0]  DECK_A_LAST    = 5'd5;
    localparam logic [SRC_W-1:0]  DECK_B_LAST    = 5'd11;
    localparam logic [SENT_W-1:0] SENT_RESET     = 8'd255;
    localparam logic [10:0]       SCALE_DIV      = 11'd1023;

    localparam logic [VAL_W-1:0] CC_TABLE [TABLE_SIZE] = '{
        7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
        7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
        7'd26, 7'd27, 7'd28, 7'd29
    };

    typedef struct packed {
        logic [SRC_W-1:0] source_index;
        logic [RAW_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  midi_channel;
        logic [VAL_W-1:0] controller_number;
        logic [VAL_W-1:0] cc_value;
    } out_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  deck_a_channel;
        logic [CH_W-1:0]  deck_b_channel;
        logic             cue_mix_mode;
        logic [RAW_W-1:0] raw_threshold;
        logic [VAL_W-1:0] value_threshold;
    } cfg_t;

    typedef struct packed {
        logic      emit;
        logic      raw_update;
        out_item_t data;
    } eval_t;

endpackage

`default_nettype wire

// ===== hdl/pot_deadband_to_control_change.sv =====
// top level: pot and crossfader deadband filter emitting control-change requests
// depends on pdcc_pkg, pdcc_ram, pdcc_cfg_regs, pdcc_eval
//
// One request per cycle is accepted while the output is not stalled; its result
// is registered from the evaluation stage. Per-source history lives in two small
// rams (last raw sample per pot, last sent value per pot and crossfader) that are
// read as the request enters and written back from the evaluation stage; a write
// is forwarded to the request directly behind it. Reset state is held in
// per-entry valid flags, so the block is ready right after reset with no
// clearing pass. A stalled output holds the evaluation stage and so the input.
`default_nettype none

module pot_deadband_to_control_change #(
    parameter int POT_COUNT = pdcc_pkg::POT_COUNT_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pdcc_pkg::in_item_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pdcc_pkg::out_item_t m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [9:0]    cfg_data
);
    import pdcc_pkg::*;

    localparam int RAW_AW  = (POT_COUNT > 1) ? $clog2(POT_COUNT) : 1;
    localparam int SENT_AW = $clog2(POT_COUNT + 1);

    cfg_t      cfg;
    eval_t     ev;

    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;

    logic [POT_COUNT-1:0] raw_valid_reg, raw_valid_next;
    logic [POT_COUNT:0]   sent_valid_reg, sent_valid_next;

    logic               raw_fwd_valid_reg;
    logic [RAW_AW-1:0]  raw_fwd_addr_reg;
    logic [RAW_W-1:0]   raw_fwd_data_reg;
    logic               sent_fwd_valid_reg;
    logic [SENT_AW-1:0] sent_fwd_addr_reg;
    logic [SENT_W-1:0]  sent_fwd_data_reg;

    logic               out_free;
    logic               fire;
    logic               accept;
    in_item_t           rd_item;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   s1_idx;
    logic [RAW_AW-1:0]  raw_raddr, raw_addr_s1;
    logic [SENT_AW-1:0] sent_raddr, sent_addr_s1;
    logic [RAW_W-1:0]   raw_rdata, raw_old;
    logic [SENT_W-1:0]  sent_rdata, sent_old;
    logic               raw_we, sent_we;
    logic               raw_hit, sent_hit;

    pdcc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || fire;
    assign accept   = s_valid && s_ready;

    // re-read the held request while stalled so the ram output stays current
    assign rd_item      = s_ready ? s_data : s1_item_reg;
    assign rd_idx       = IDX_W'(rd_item.source_index);
    assign s1_idx       = IDX_W'(s1_item_reg.source_index);
    assign raw_raddr    = rd_idx[RAW_AW-1:0];
    assign sent_raddr   = rd_idx[SENT_AW-1:0];
    assign raw_addr_s1  = s1_idx[RAW_AW-1:0];
    assign sent_addr_s1 = s1_idx[SENT_AW-1:0];

    pdcc_ram #(.WIDTH(RAW_W), .DEPTH(POT_COUNT)) u_raw_ram (
        .aclk  (aclk),
        .we    (raw_we),
        .waddr (raw_addr_s1),
        .wdata (s1_item_reg.sample),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    pdcc_ram #(.WIDTH(SENT_W), .DEPTH(POT_COUNT + 1)) u_sent_ram (
        .aclk  (aclk),
        .we    (sent_we),
        .waddr (sent_addr_s1),
        .wdata ({1'b0, ev.data.cc_value}),
        .raddr (sent_raddr),
        .rdata (sent_rdata)
    );

    assign raw_hit  = raw_fwd_valid_reg && (raw_fwd_addr_reg == raw_addr_s1);
    assign sent_hit = sent_fwd_valid_reg && (sent_fwd_addr_reg == sent_addr_s1);
    assign raw_old  = raw_hit ? raw_fwd_data_reg : raw_rdata;
    assign sent_old = sent_hit ? sent_fwd_data_reg : sent_rdata;

    pdcc_eval #(.POT_COUNT(POT_COUNT)) u_eval (
        .cfg            (cfg),
        .item           (s1_item_reg),
        .raw_old        (raw_old),
        .raw_old_valid  (raw_valid_reg[raw_addr_s1]),
        .sent_old       (sent_old),
        .sent_old_valid (sent_valid_reg[sent_addr_s1]),
        .result         (ev)
    );

    assign raw_we  = fire && ev.raw_update;
    assign sent_we = fire && ev.emit;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (fire) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = ev.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        raw_valid_next = raw_valid_reg;
        if (raw_we) begin
            raw_valid_next[raw_addr_s1] = 1'b1;
        end
        sent_valid_next = sent_valid_reg;
        if (sent_we) begin
            sent_valid_next[sent_addr_s1] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            raw_valid_reg      <= '0;
            sent_valid_reg     <= '0;
            raw_fwd_valid_reg  <= 1'b0;
            sent_fwd_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg       <= s1_valid_next;
            m_valid_reg        <= m_valid_next;
            raw_valid_reg      <= raw_valid_next;
            sent_valid_reg     <= sent_valid_next;
            raw_fwd_valid_reg  <= raw_we;
            sent_fwd_valid_reg <= sent_we;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_data;
        end
        if (fire && ev.emit) begin
            m_data_reg <= ev.data;
        end
        raw_fwd_addr_reg  <= raw_addr_s1;
        raw_fwd_data_reg  <= s1_item_reg.sample;
        sent_fwd_addr_reg <= sent_addr_s1;
        sent_fwd_data_reg <= {1'b0, ev.data.cc_value};
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a request in the evaluation stage");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the evaluation stage is held");

    a_sent_marked_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        sent_we |=> sent_valid_reg[$past(sent_addr_s1)])
        else $error("sent entry written but not marked valid");

    a_raw_needs_pot: assert property (@(posedge aclk) disable iff (!aresetn)
        raw_we |-> (IDX_W'(s1_item_reg.source_index) < IDX_W'(POT_COUNT)))
        else $error("raw history written for a source that is not a pot");

endmodule

`default_nettype wire

// ===== hdl/pdcc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module pdcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/pdcc_cfg_regs.sv =====
// configuration register bank written through its own valid/ready port
// depends on pdcc_pkg
`default_nettype none

module pdcc_cfg_regs (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [9:0]         cfg_data,
    output pdcc_pkg::cfg_t          cfg
);
    import pdcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DECK_A_CHANNEL:  cfg_next.deck_a_channel  = cfg_data[CH_W-1:0];
                REG_DECK_B_CHANNEL:  cfg_next.deck_b_channel  = cfg_data[CH_W-1:0];
                REG_CUE_MIX_MODE:    cfg_next.cue_mix_mode    = cfg_data[0];
                REG_RAW_THRESHOLD:   cfg_next.raw_threshold   = cfg_data[RAW_W-1:0];
                REG_VALUE_THRESHOLD: cfg_next.value_threshold = cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deck_a_channel  <= DECK_A_RESET;
            cfg_reg.deck_b_channel  <= DECK_B_RESET;
            cfg_reg.cue_mix_mode    <= 1'b0;
            cfg_reg.raw_threshold   <= RAW_THRESHOLD_RESET;
            cfg_reg.value_threshold <= VALUE_THRESHOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pdcc_eval.sv =====
// both deadbands, scaling and message fields for one request in the read stage
// depends on pdcc_pkg
`default_nettype none

module pdcc_eval #(
    parameter int POT_COUNT = pdcc_pkg::POT_COUNT_DEFAULT
) (
    input  wire pdcc_pkg::cfg_t         cfg,
    input  wire pdcc_pkg::in_item_t     item,
    input  wire logic [9:0]             raw_old,
    input  wire logic                   raw_old_valid,
    input  wire logic [7:0]             sent_old,
    input  wire logic                   sent_old_valid,
    output pdcc_pkg::eval_t             result
);
    import pdcc_pkg::*;

    localparam logic [IDX_W-1:0] XF_IDX = IDX_W'(POT_COUNT);

    logic [IDX_W-1:0]  src_ext;
    logic              is_pot;
    logic              is_xf;
    logic [RAW_W-1:0]  raw_diff;
    logic              raw_block;
    logic [16:0]       prod;
    logic [VAL_W-1:0]  quot;
    logic [10:0]       rem;
    logic [VAL_W-1:0]  val;
    logic [SENT_W-1:0] sent_cmp;
    logic [SENT_W-1:0] val_diff;
    logic              pass_val;
    logic [VAL_W-1:0]  cc;
    logic [CH_W-1:0]   ch;

    always_comb begin
        src_ext = IDX_W'(item.source_index);
        is_pot  = src_ext < XF_IDX;
        is_xf   = src_ext == XF_IDX;

        raw_diff  = (item.sample > raw_old) ? (item.sample - raw_old)
                                            : (raw_old - item.sample);
        raw_block = is_pot && raw_old_valid && (raw_diff < cfg.raw_threshold);

        // sample * 127 / 1023 with one correction step
        prod = {item.sample, 7'b0} - 17'(item.sample);
        quot = prod[16:10];
        rem  = {1'b0, prod[9:0]} + 11'(quot);
        val  = (rem >= SCALE_DIV) ? quot + 7'd1 : quot;

        sent_cmp = sent_old_valid ? sent_old : SENT_RESET;
        val_diff = ({1'b0, val} > sent_cmp) ? ({1'b0, val} - sent_cmp)
                                            : (sent_cmp - {1'b0, val});
        pass_val = val_diff >= {1'b0, cfg.value_threshold};

        if (is_xf) begin
            cc = XF_CC;
        end else if (src_ext < IDX_W'(TABLE_SIZE)) begin
            cc = CC_TABLE[item.source_index[3:0]];
        end else begin
            cc = VAL_W'(item.source_index);
        end
        if (!is_xf && item.source_index == CUE_POT && cfg.cue_mix_mode) begin
            cc = CUE_ALT_CC;
        end

        priority if (is_xf) begin
            ch = XF_CHANNEL;
        end else if (item.source_index <= DECK_A_LAST) begin
            ch = cfg.deck_a_channel;
        end else if (item.source_index <= DECK_B_LAST) begin
            ch = cfg.deck_b_channel;
        end else begin
            ch = GLOBAL_CHANNEL;
        end

        result.raw_update             = is_pot && !raw_block;
        result.emit                   = (is_xf || (is_pot && !raw_block)) && pass_val;
        result.data.midi_channel      = ch;
        result.data.controller_number = cc;
        result.data.cc_value          = val;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_pot_deadband_to_control_change.sv =====
// testbench for pot_deadband_to_control_change: directed and random samples,
// register settings and output backpressure, checked against an in-bench predictor
// depends on pdcc_pkg and pot_deadband_to_control_change
module tb_pot_deadband_to_control_change;
    timeunit 1ns;
    timeprecision 1ps;

    import pdcc_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          XFADER_INDEX    = 16;
    localparam int          CUE_SRC         = 1;
    localparam int          DECK_A_MAX      = 5;
    localparam int          DECK_B_MAX      = 11;
    localparam int          SCALE_MUL       = 127;
    localparam int          SCALE_DEN       = 1023;
    localparam int          RAW_MAX         = 1023;
    localparam logic [2:0]  REG_SPARE       = 3'd7;
    localparam logic [4:0]  GLOBAL_CH       = 5'd1;
    localparam logic [4:0]  XFADER_CH       = 5'd1;
    localparam logic [6:0]  XFADER_CC       = 7'd8;
    localparam logic [6:0]  CUE_CC          = 7'd40;
    localparam logic [6:0]  POT_CC [16]     = '{
        7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
        7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
        7'd26, 7'd27, 7'd28, 7'd29
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [9:0] cfg_data  = '0;

    // predictor state and register copy
    logic [4:0] deck_a_ch;
    logic [4:0] deck_b_ch;
    logic       cue_mix;
    logic [9:0] raw_thr;
    logic [6:0] value_thr;
    bit         raw_seen  [16];
    logic [9:0] raw_hist  [16];
    logic [7:0] sent_hist [17];

    out_item_t   cc_expect_q[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_off_req   = 0;
    int unsigned burst_left     = 0;
    bit          sender_gaps    = 1'b1;
    logic [9:0]  last_offered [32];

    pot_deadband_to_control_change u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned abs_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic void reset_predictor();
        deck_a_ch = DECK_A_RESET;
        deck_b_ch = DECK_B_RESET;
        cue_mix   = 1'b0;
        raw_thr   = RAW_THRESHOLD_RESET;
        value_thr = VALUE_THRESHOLD_RESET;
        for (int i = 0; i < 16; i++) begin
            raw_seen[i] = 1'b0;
            raw_hist[i] = '0;
        end
        for (int i = 0; i < 17; i++) sent_hist[i] = 8'd255;
        for (int i = 0; i < 32; i++) last_offered[i] = 10'd512;
    endfunction

    function automatic void predict_control_change(input in_item_t req);
        int unsigned src;
        int unsigned raw;
        int unsigned level;
        out_item_t   cc;
        src = req.source_index;
        raw = req.sample;
        if (src > XFADER_INDEX) return;
        level = raw * SCALE_MUL / SCALE_DEN;
        if (src != XFADER_INDEX) begin
            if (raw_seen[src] && abs_gap(raw, raw_hist[src]) < raw_thr) return;
            raw_seen[src] = 1'b1;
            raw_hist[src] = req.sample;
        end
        if (abs_gap(level, sent_hist[src]) < value_thr) return;
        sent_hist[src] = 8'(level);
        if (src == XFADER_INDEX) begin
            cc.midi_channel      = XFADER_CH;
            cc.controller_number = XFADER_CC;
        end else begin
            cc.controller_number = (src == CUE_SRC && cue_mix) ? CUE_CC : POT_CC[src];
            if (src <= DECK_A_MAX) cc.midi_channel = deck_a_ch;
            else if (src <= DECK_B_MAX) cc.midi_channel = deck_b_ch;
            else cc.midi_channel = GLOBAL_CH;
        end
        cc.cc_value = 7'(level);
        cc_expect_q.push_back(cc);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", what);
    endfunction

    // result checker
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cc_expect_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result: ch %0d cc %0d val %0d",
                    m_data.midi_channel, m_data.controller_number, m_data.cc_value));
            end else begin
                want = cc_expect_q.pop_front();
                if (m_data.midi_channel !== want.midi_channel ||
                    m_data.controller_number !== want.controller_number ||
                    m_data.cc_value !== want.cc_value) begin
                    note_mismatch($sformatf(
                        "mismatch: expected ch %0d cc %0d val %0d, got ch %0d cc %0d val %0d",
                        want.midi_channel, want.controller_number, want.cc_value,
                        m_data.midi_channel, m_data.controller_number, m_data.cc_value));
                end
            end
        end
    end

    // receiver stall pattern, with a forced hold-off on request
    initial begin : ready_pattern
        int unsigned hold_count;
        int unsigned stretch_left;
        int unsigned stall_pct;
        hold_count   = 0;
        stretch_left = 0;
        stall_pct    = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req != 0) begin
                hold_count   = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_count != 0) begin
                hold_count--;
                m_ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(4, 60);
                    case ($urandom_range(2))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        default: stall_pct = 60;
                    endcase
                end
                stretch_left--;
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL pot_deadband_to_control_change");
        $finish;
    end

    task automatic send_sample(input logic [4:0] src, input logic [9:0] smp);
        in_item_t    req;
        int unsigned gap;
        req.source_index = src;
        req.sample       = smp;
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_control_change(req);
        last_offered[src] = smp;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = sender_gaps ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cc_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [9:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_DECK_A_CHANNEL:  deck_a_ch = value[4:0];
            REG_DECK_B_CHANNEL:  deck_b_ch = value[4:0];
            REG_CUE_MIX_MODE:    cue_mix   = value[0];
            REG_RAW_THRESHOLD:   raw_thr   = value;
            REG_VALUE_THRESHOLD: value_thr = value[6:0];
            default: ;
        endcase
    endtask

    // unused upper bits carry random junk
    task automatic apply_settings(input logic [4:0] ch_a, input logic [4:0] ch_b,
                                  input logic cue, input logic [9:0] rthr,
                                  input logic [6:0] vthr);
        logic [9:0] junk;
        wait_drained();
        junk = 10'($urandom);
        write_register(REG_DECK_A_CHANNEL, {junk[4:0], ch_a});
        write_register(REG_DECK_B_CHANNEL, {junk[9:5], ch_b});
        junk = 10'($urandom);
        write_register(REG_CUE_MIX_MODE, {junk[8:0], cue});
        write_register(REG_RAW_THRESHOLD, rthr);
        write_register(REG_VALUE_THRESHOLD, {junk[2:0], vthr});
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_sample();
        int unsigned pick;
        int          level;
        logic [4:0]  src;
        logic [9:0]  smp;
        pick = $urandom_range(99);
        if (pick < 8) src = 5'($urandom_range(17, 31));
        else src = 5'($urandom_range(0, XFADER_INDEX));
        pick = $urandom_range(99);
        if (pick < 55) begin
            smp = 10'($urandom);
        end else if (pick < 65) begin
            smp = $urandom_range(1) ? 10'd1023 : 10'd0;
        end else begin
            level = int'(last_offered[src]) + int'($urandom_range(0, 80)) - 40;
            if (level < 0) level = 0;
            if (level > RAW_MAX) level = RAW_MAX;
            smp = 10'(level);
        end
        send_sample(src, smp);
    endtask

    // reset values, both deadbands, crossfader and unknown sources
    task automatic test_reset_defaults();
        send_sample(5'd0, 10'd0);
        send_sample(5'd0, 10'd10);
        send_sample(5'd0, 10'd1023);
        send_sample(5'd0, 10'd1000);
        send_sample(5'd0, 10'd985);
        send_sample(5'd0, 10'd1000);
        send_sample(5'd1, 10'd512);
        send_sample(5'd5, 10'd1023);
        send_sample(5'd6, 10'd0);
        send_sample(5'd11, 10'd1023);
        send_sample(5'd12, 10'd300);
        send_sample(5'd15, 10'd777);
        send_sample(5'd16, 10'd0);
        send_sample(5'd16, 10'd10);
        send_sample(5'd16, 10'd1023);
        send_sample(5'd16, 10'd1015);
        send_sample(5'd17, 10'd1023);
        send_sample(5'd31, 10'd0);
        send_sample(5'd24, 10'd555);
        send_sample(5'd7, 10'd256);
        send_sample(5'd10, 10'd341);
    endtask

    // channel extremes, out-of-range channels, cue mix, threshold extremes
    task automatic test_register_settings();
        bit flip;
        flip = 1'b1;
        wait_drained();
        write_register(REG_SPARE, 10'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: apply_settings(5'd1, 5'd16, 1'b1, 10'd0, 7'd0);
                1: apply_settings(5'd16, 5'd1, 1'b0, 10'd1023, 7'd127);
                2: apply_settings(5'd0, 5'd31, 1'b1, 10'd1, 7'd1);
                default: apply_settings(5'd31, 5'd0, 1'b0, 10'd15, 7'd3);
            endcase
            for (int k = 0; k <= XFADER_INDEX; k++) begin
                send_sample(5'(k), flip ? 10'd1023 : 10'd0);
            end
            for (int k = 0; k < 8; k++) send_random_sample();
            flip = !flip;
        end
    endtask

    // long receiver hold-off with the sender offering every cycle
    task automatic test_output_backpressure();
        apply_settings(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                       1'($urandom_range(1)), 10'd0, 7'd0);
        sender_gaps  = 1'b0;
        hold_off_req = HOLD_OFF_CYCLES;
        for (int k = 0; k < 40; k++) send_sample(5'(k % 17), 10'($urandom));
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_settings(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                                  1'b1, 10'd0, 7'd0);
                1: apply_settings(5'($urandom), 5'($urandom), 1'b0, 10'd1023, 7'd127);
                default: apply_settings(5'($urandom_range(1, 16)),
                                        5'($urandom_range(1, 16)),
                                        1'($urandom_range(1)),
                                        10'($urandom_range(0, 40)),
                                        7'($urandom_range(0, 8)));
            endcase
            for (int k = 0; k < 120; k++) send_random_sample();
        end
    endtask

    initial begin
        reset_predictor();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0 && cc_expect_q.size() == 0) begin
            $display("PASS pot_deadband_to_control_change");
        end else begin
            $display("FAIL pot_deadband_to_control_change");
        end
        $finish;
    end

endmodule
